// ===== rtl/fqd_pkg.sv =====
package fqd_pkg;

   // Fixed payload widths of the channels
   localparam int MODE_W   = 2;
   localparam int HANDLE_W = 32;
   localparam int LENGTH_W = 5;

   typedef logic [MODE_W-1:0]   mode_type;
   typedef logic [HANDLE_W-1:0] handle_type;
   typedef logic [LENGTH_W-1:0] length_type;

   // Operation codes
   localparam mode_type MODE_ENQ = 2'd0;
   localparam mode_type MODE_DEQ = 2'd1;
   localparam mode_type MODE_DEL = 2'd2;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic capture;     // latch the request payload
      logic enq;         // write the key at the tail, grow by one
      logic deq_rd;      // read the head entry
      logic deq_pop;     // take the read head, advance head, shrink by one
      logic scan_start;  // set up a delete scan from the head
      logic scan_step;   // advance the delete scan by one entry
      logic del_commit;  // shrink by one after a matched delete
      logic rsp_load;    // load the response register
      logic fail;        // status bit to load with the response
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      mode_type mode;
      logic     full;
      logic     empty;
      logic     null_key;
      logic     scan_done;
      logic     found;
   } stat_type;

endpackage

// ===== rtl/fqd_if.sv =====
interface fqd_req_if;
   logic                 valid;
   logic                 ready;
   fqd_pkg::mode_type    mode;
   fqd_pkg::handle_type  handle;

   modport source (output valid, output mode, output handle, input ready);
   modport sink   (input valid, input mode, input handle, output ready);
endinterface

interface fqd_rsp_if;
   logic                 valid;
   logic                 ready;
   logic                 status;
   fqd_pkg::handle_type  out_handle;
   fqd_pkg::length_type  length;

   modport source (output valid, output status, output out_handle, output length, input ready);
   modport sink   (input valid, input status, input out_handle, input length, output ready);
endinterface

// ===== rtl/fifo_queue_with_delete.sv =====
// Channel  Dir  Fields                        Transfer
// req      in   mode[1:0], handle[31:0]       valid && ready
// rsp      out  status, out_handle[31:0],     valid && ready
//               length[4:0]
//
// One operation at a time. Response valid follows the request transfer via the decode
// and response states for enqueue and failed decodes, decode, pop and response for
// dequeue, and decode, the one-entry-per-cycle scan and response for delete.
// A new request is taken while the previous response waits in the output
// register; a stalled response holds the block before its result is loaded.
// Reset is synchronous and empties the queue at once; stored entries are not cleared.

module fifo_queue_with_delete #(
   parameter int DEPTH        = 16,
   parameter int HANDLE_WIDTH = 32
) (
   input  logic         clock,
   input  logic         reset,
   fqd_req_if.sink      req_chan,
   fqd_rsp_if.source    rsp_chan
);

   fqd_pkg::cmd_type  cmd;
   fqd_pkg::stat_type stat;

   fqd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   fqd_dpath #(
      .DEPTH        (DEPTH),
      .HANDLE_WIDTH (HANDLE_WIDTH)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .req_mode       (req_chan.mode),
      .req_handle     (req_chan.handle),
      .cmd            (cmd),
      .stat           (stat),
      .rsp_status     (rsp_chan.status),
      .rsp_out_handle (rsp_chan.out_handle),
      .rsp_length     (rsp_chan.length)
   );

endmodule

// ===== rtl/fqd_dpath.sv =====
module fqd_dpath #(
   parameter int DEPTH        = 16,
   parameter int HANDLE_WIDTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  fqd_pkg::mode_type    req_mode,
   input  fqd_pkg::handle_type  req_handle,
   input  fqd_pkg::cmd_type     cmd,
   output fqd_pkg::stat_type    stat,
   output logic                 rsp_status,
   output fqd_pkg::handle_type  rsp_out_handle,
   output fqd_pkg::length_type  rsp_length
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = AW + 1;

   typedef logic [HANDLE_WIDTH-1:0] ent_type;
   typedef logic [AW-1:0]           addr_type;
   typedef logic [CW-1:0]           cnt_type;
   typedef logic [SW-1:0]           sum_type;

   function automatic addr_type next_addr(input addr_type a);
      addr_type r;
      if (a == addr_type'(DEPTH - 1)) begin
         r = '0;
      end else begin
         r = a + 1'b1;
      end
      return r;
   endfunction

   // Queue storage, circular with a head pointer
   ent_type  mem_ff [DEPTH];
   ent_type  rdata_ff;

   cnt_type  count_ff, count_in;
   addr_type head_ff, head_in;
   fqd_pkg::mode_type mode_ff, mode_in;
   ent_type  key_ff, key_in;
   ent_type  res_handle_ff, res_handle_in;

   // Delete scan state
   addr_type scan_addr_ff, scan_addr_in;
   cnt_type  left_ff, left_in;
   logic     rvalid_ff, rvalid_in;
   addr_type dat_addr_ff, dat_addr_in;
   logic     found_ff, found_in;
   addr_type gap_ff, gap_in;

   logic                 rsp_status_ff, rsp_status_in;
   fqd_pkg::handle_type  rsp_handle_ff, rsp_handle_in;
   fqd_pkg::length_type  rsp_length_ff, rsp_length_in;

   sum_type  tail_sum;
   addr_type tail;
   logic     left_nz;
   logic     wr_en, rd_en;
   addr_type wr_addr, rd_addr;
   ent_type  wr_data;

   // Tail address, head plus count modulo depth
   assign tail_sum = sum_type'(head_ff) + sum_type'(count_ff);
   assign tail     = (tail_sum >= sum_type'(DEPTH)) ? addr_type'(tail_sum - sum_type'(DEPTH))
                                                    : addr_type'(tail_sum);
   assign left_nz  = (left_ff != '0);

   // Memory port selection
   assign wr_en   = cmd.enq | (cmd.scan_step & rvalid_ff & found_ff);
   assign wr_addr = cmd.enq ? tail : gap_ff;
   assign wr_data = cmd.enq ? key_ff : rdata_ff;
   assign rd_en   = cmd.deq_rd | (cmd.scan_step & left_nz);
   assign rd_addr = cmd.deq_rd ? head_ff : scan_addr_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem_ff[rd_addr];
      end
   end

   // Next state of the queue and the scan
   always_comb begin
      count_in      = count_ff;
      head_in       = head_ff;
      mode_in       = mode_ff;
      key_in        = key_ff;
      res_handle_in = res_handle_ff;
      scan_addr_in  = scan_addr_ff;
      left_in       = left_ff;
      rvalid_in     = rvalid_ff;
      dat_addr_in   = dat_addr_ff;
      found_in      = found_ff;
      gap_in        = gap_ff;
      rsp_status_in = rsp_status_ff;
      rsp_handle_in = rsp_handle_ff;
      rsp_length_in = rsp_length_ff;

      if (cmd.capture) begin
         mode_in       = req_mode;
         key_in        = ent_type'(req_handle);
         res_handle_in = '0;
      end
      if (cmd.enq) begin
         count_in = count_ff + 1'b1;
      end
      if (cmd.deq_pop) begin
         res_handle_in = rdata_ff;
         head_in       = next_addr(head_ff);
         count_in      = count_ff - 1'b1;
      end
      if (cmd.del_commit) begin
         count_in = count_ff - 1'b1;
      end
      if (cmd.scan_start) begin
         scan_addr_in = head_ff;
         left_in      = count_ff;
         rvalid_in    = 1'b0;
         found_in     = 1'b0;
      end
      if (cmd.scan_step) begin
         // read side: fetch the next entry
         rvalid_in   = left_nz;
         dat_addr_in = scan_addr_ff;
         if (left_nz) begin
            scan_addr_in = next_addr(scan_addr_ff);
            left_in      = left_ff - 1'b1;
         end
         // compare side: find the match, then move later entries down
         if (rvalid_ff) begin
            if (found_ff) begin
               gap_in = dat_addr_ff;
            end else if (rdata_ff == key_ff) begin
               found_in = 1'b1;
               gap_in   = dat_addr_ff;
            end
         end
      end
      if (cmd.rsp_load) begin
         rsp_status_in = cmd.fail;
         rsp_handle_in = fqd_pkg::handle_type'(res_handle_ff);
         rsp_length_in = fqd_pkg::length_type'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         head_ff   <= '0;
         left_ff   <= '0;
         rvalid_ff <= 1'b0;
         found_ff  <= 1'b0;
      end else begin
         count_ff  <= count_in;
         head_ff   <= head_in;
         left_ff   <= left_in;
         rvalid_ff <= rvalid_in;
         found_ff  <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      key_ff        <= key_in;
      res_handle_ff <= res_handle_in;
      scan_addr_ff  <= scan_addr_in;
      dat_addr_ff   <= dat_addr_in;
      gap_ff        <= gap_in;
      rsp_status_ff <= rsp_status_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_length_ff <= rsp_length_in;
   end

   // Status to the controller
   always_comb begin
      stat.mode      = mode_ff;
      stat.full      = (count_ff == cnt_type'(DEPTH));
      stat.empty     = (count_ff == '0);
      stat.null_key  = (key_ff == '0);
      stat.scan_done = !left_nz && !rvalid_ff;
      stat.found     = found_ff;
   end

   assign rsp_status     = rsp_status_ff;
   assign rsp_out_handle = rsp_handle_ff;
   assign rsp_length     = rsp_length_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= cnt_type'(DEPTH))
      else $error("queue length above depth");

   a_head_bound: assert property (@(posedge clock) disable iff (reset)
      head_ff <= addr_type'(DEPTH - 1))
      else $error("head pointer out of range");

   a_pop_shrinks: assert property (@(posedge clock) disable iff (reset)
      cmd.deq_pop |=> count_ff == $past(count_ff) - 1'b1)
      else $error("dequeue did not shrink the queue by one");

   a_no_grow_full: assert property (@(posedge clock) disable iff (reset)
      cmd.enq |-> count_ff != cnt_type'(DEPTH))
      else $error("enqueue issued on a full queue");

endmodule

// ===== rtl/fqd_ctrl.sv =====
module fqd_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  fqd_pkg::stat_type  stat,
   output fqd_pkg::cmd_type   cmd
);

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_DECODE  = 3'd1;
   localparam logic [2:0] ST_DEQ_POP = 3'd2;
   localparam logic [2:0] ST_SCAN    = 3'd3;
   localparam logic [2:0] ST_RESP    = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       fail_ff, fail_in;
   logic       rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == ST_IDLE);

   // Sequence one operation
   always_comb begin
      state_in = state_ff;
      fail_in  = fail_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECODE;
            end
         end
         ST_DECODE: begin
            fail_in  = 1'b1;
            state_in = ST_RESP;
            case (stat.mode)
               fqd_pkg::MODE_ENQ: begin
                  if (!stat.full) begin
                     cmd.enq = 1'b1;
                     fail_in = 1'b0;
                  end
               end
               fqd_pkg::MODE_DEQ: begin
                  if (!stat.empty) begin
                     cmd.deq_rd = 1'b1;
                     fail_in    = 1'b0;
                     state_in   = ST_DEQ_POP;
                  end
               end
               fqd_pkg::MODE_DEL: begin
                  if (!stat.null_key && !stat.empty) begin
                     cmd.scan_start = 1'b1;
                     state_in       = ST_SCAN;
                  end
               end
               default: begin
                  fail_in = 1'b1;
               end
            endcase
         end
         ST_DEQ_POP: begin
            cmd.deq_pop = 1'b1;
            state_in    = ST_RESP;
         end
         ST_SCAN: begin
            if (stat.scan_done) begin
               fail_in        = !stat.found;
               cmd.del_commit = stat.found;
               state_in       = ST_RESP;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         ST_RESP: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      cmd.fail = fail_ff;
   end

   // Hold the result until its transfer
   always_comb begin
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fail_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fail_ff      <= fail_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      !(cmd.rsp_load && rsp_valid_ff && !rsp_ready))
      else $error("response register overwritten before transfer");

   a_accept_decodes: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> state_ff == ST_DECODE)
      else $error("accepted request not decoded");

   a_scan_no_accept: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> !req_ready && !cmd.rsp_load)
      else $error("new request or response during delete scan");

endmodule

// ===== dv/fifo_queue_with_delete_tb.sv =====
`timescale 1ns / 100ps

module fifo_queue_with_delete_tb;

   localparam int DEPTH       = 16;
   localparam int CYCLE_LIMIT = 400000;
   localparam int LONG_HOLD   = 80;
   localparam int SEGMENTS    = 9;
   localparam int SEG_ITEMS   = 100;
   localparam int POOL_SIZE   = 6;

   // Code with no meaning to the block; it must fail and change nothing
   localparam fqd_pkg::mode_type MODE_BAD = 2'd3;

   typedef struct packed {
      logic                status;
      fqd_pkg::handle_type out_handle;
      fqd_pkg::length_type length;
   } queue_rsp_type;

   typedef struct packed {
      fqd_pkg::mode_type   op;
      fqd_pkg::handle_type key;
      logic [7:0]          reps;
      logic                typed;
      logic                status;
      fqd_pkg::handle_type out_handle;
      fqd_pkg::length_type length;
   } stim_row_type;

   logic clock;
   logic reset;

   fqd_req_if req_chan ();
   fqd_rsp_if rsp_chan ();

   fifo_queue_with_delete #(
      .DEPTH        (DEPTH),
      .HANDLE_WIDTH (fqd_pkg::HANDLE_W)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Shadow of the queue contents, oldest at index 0
   fqd_pkg::handle_type queue_image [0:DEPTH-1];
   int                  queue_fill = 0;

   queue_rsp_type pending_rsps [$];
   int            mismatches = 0;
   int            cycle_count = 0;

   // Side information for the item on offer
   logic          offer_typed = 1'b0;
   queue_rsp_type offer_typed_rsp = '0;

   // Sender and receiver controls
   bit quiet = 1'b0;
   bit long_hold_req = 1'b0;

   // Directed stimulus: typed expectations only where obvious
   stim_row_type dir_rows [0:24] = '{
      {fqd_pkg::MODE_DEQ, 32'h0000_0000, 8'd1,  1'b1, 1'b1, 32'h0000_0000, 5'd0},
      {fqd_pkg::MODE_DEL, 32'h0000_0005, 8'd1,  1'b1, 1'b1, 32'h0000_0000, 5'd0},
      {fqd_pkg::MODE_DEL, 32'h0000_0000, 8'd1,  1'b1, 1'b1, 32'h0000_0000, 5'd0},
      {MODE_BAD,          32'hA5A5_A5A5, 8'd1,  1'b1, 1'b1, 32'h0000_0000, 5'd0},
      {fqd_pkg::MODE_ENQ, 32'hFFFF_FFFF, 8'd1,  1'b1, 1'b0, 32'h0000_0000, 5'd1},
      {fqd_pkg::MODE_ENQ, 32'h0000_0000, 8'd1,  1'b1, 1'b0, 32'h0000_0000, 5'd2},
      {fqd_pkg::MODE_DEL, 32'h0000_0000, 8'd1,  1'b1, 1'b1, 32'h0000_0000, 5'd2},
      {fqd_pkg::MODE_DEQ, 32'h0000_0000, 8'd1,  1'b1, 1'b0, 32'hFFFF_FFFF, 5'd1},
      {fqd_pkg::MODE_DEQ, 32'h0000_0000, 8'd1,  1'b1, 1'b0, 32'h0000_0000, 5'd0},
      {fqd_pkg::MODE_ENQ, 32'h1000_0001, 8'd16, 1'b0, 1'b0, 32'h0000_0000, 5'd0},
      {fqd_pkg::MODE_ENQ, 32'hDEAD_BEEF, 8'd1,  1'b1, 1'b1, 32'h0000_0000, 5'd16},
      {fqd_pkg::MODE_DEL, 32'h1000_0001, 8'd1,  1'b1, 1'b0, 32'h0000_0000, 5'd15},
      {fqd_pkg::MODE_DEL, 32'h1000_0010, 8'd1,  1'b1, 1'b0, 32'h0000_0000, 5'd14},
      {fqd_pkg::MODE_DEL, 32'h1000_0008, 8'd1,  1'b1, 1'b0, 32'h0000_0000, 5'd13},
      {fqd_pkg::MODE_DEL, 32'h1000_0008, 8'd1,  1'b1, 1'b1, 32'h0000_0000, 5'd13},
      {MODE_BAD,          32'h5A5A_5A5A, 8'd1,  1'b1, 1'b1, 32'h0000_0000, 5'd13},
      {fqd_pkg::MODE_DEQ, 32'h0000_0000, 8'd1,  1'b1, 1'b0, 32'h1000_0002, 5'd12},
      {fqd_pkg::MODE_DEQ, 32'h0000_0000, 8'd12, 1'b0, 1'b0, 32'h0000_0000, 5'd0},
      {fqd_pkg::MODE_DEQ, 32'h0000_0000, 8'd1,  1'b1, 1'b1, 32'h0000_0000, 5'd0},
      {fqd_pkg::MODE_ENQ, 32'h0000_0007, 8'd1,  1'b0, 1'b0, 32'h0000_0000, 5'd0},
      {fqd_pkg::MODE_ENQ, 32'h0000_0009, 8'd1,  1'b0, 1'b0, 32'h0000_0000, 5'd0},
      {fqd_pkg::MODE_ENQ, 32'h0000_0007, 8'd1,  1'b0, 1'b0, 32'h0000_0000, 5'd0},
      {fqd_pkg::MODE_DEL, 32'h0000_0007, 8'd1,  1'b0, 1'b0, 32'h0000_0000, 5'd0},
      {fqd_pkg::MODE_DEQ, 32'h0000_0000, 8'd1,  1'b0, 1'b0, 32'h0000_0000, 5'd0},
      {fqd_pkg::MODE_DEQ, 32'h0000_0000, 8'd1,  1'b0, 1'b0, 32'h0000_0000, 5'd0}
   };

   // Apply one operation to the shadow queue and return its response
   function automatic queue_rsp_type queue_apply(fqd_pkg::mode_type op,
                                                 fqd_pkg::handle_type key);
      queue_rsp_type r;
      int            hit;
      r.status     = 1'b1;
      r.out_handle = '0;
      hit          = -1;
      case (op)
         fqd_pkg::MODE_ENQ: begin
            if (queue_fill < DEPTH) begin
               queue_image[queue_fill] = key;
               queue_fill++;
               r.status = 1'b0;
            end
         end
         fqd_pkg::MODE_DEQ: begin
            if (queue_fill != 0) begin
               r.out_handle = queue_image[0];
               for (int i = 1; i < queue_fill; i++)
                  queue_image[i-1] = queue_image[i];
               queue_fill--;
               r.status = 1'b0;
            end
         end
         fqd_pkg::MODE_DEL: begin
            // Null never matches, even when zero is stored
            if (key != '0) begin
               for (int i = 0; i < queue_fill; i++)
                  if (hit < 0 && queue_image[i] == key)
                     hit = i;
               if (hit >= 0) begin
                  for (int i = hit + 1; i < queue_fill; i++)
                     queue_image[i-1] = queue_image[i];
                  queue_fill--;
                  r.status = 1'b0;
               end
            end
         end
         default: ;
      endcase
      r.length = fqd_pkg::length_type'(queue_fill);
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatches++;
      $display("mismatch at %0t ns: %s got %h want %h", $time, what, got, want);
   endtask

   // Offer one item after an optional gap; return at its transfer edge
   task automatic send_op(input fqd_pkg::mode_type op, input fqd_pkg::handle_type key,
                          input logic typed, input queue_rsp_type typed_rsp);
      int gap;
      gap = (!quiet && $urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_chan.valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_chan.valid  = 1'b1;
      req_chan.mode   = op;
      req_chan.handle = key;
      offer_typed     = typed;
      offer_typed_rsp = typed_rsp;
      @(posedge clock);
      while (req_chan.ready !== 1'b1) @(posedge clock);
   endtask

   // Drop valid and hold until every response has come back
   task automatic drain;
      @(negedge clock);
      req_chan.valid = 1'b0;
      while (pending_rsps.size() != 0) @(negedge clock);
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Check responses first, then predict for a request taken at the same edge
   always @(posedge clock) begin : scoreboard
      queue_rsp_type want;
      queue_rsp_type got;
      if (!reset) begin
         if (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
            if (pending_rsps.size() == 0) begin
               report_mismatch("response with none pending", rsp_chan.out_handle, '0);
            end else begin
               want = pending_rsps.pop_front();
               if (rsp_chan.status !== want.status)
                  report_mismatch("status", 32'(rsp_chan.status), 32'(want.status));
               if (rsp_chan.out_handle !== want.out_handle)
                  report_mismatch("out_handle", rsp_chan.out_handle, want.out_handle);
               if (rsp_chan.length !== want.length)
                  report_mismatch("length", 32'(rsp_chan.length), 32'(want.length));
            end
         end
         if (req_chan.valid === 1'b1 && req_chan.ready === 1'b1) begin
            got = queue_apply(req_chan.mode, req_chan.handle);
            pending_rsps.push_back(offer_typed ? offer_typed_rsp : got);
         end
      end
   end

   // Drive response ready: long hold-off on request, else short random stalls
   initial begin : rsp_receiver
      int stall_left;
      int hold_left;
      stall_left = 0;
      hold_left  = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left     = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready = 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready = 1'b0;
         end else if (!quiet && $urandom_range(0, 4) == 0) begin
            stall_left     = $urandom_range(0, 3);
            rsp_chan.ready = 1'b0;
         end else begin
            rsp_chan.ready = 1'b1;
         end
      end
   end

   initial begin : stimulus
      fqd_pkg::handle_type key_pool [0:POOL_SIZE-1];
      queue_rsp_type       row_rsp;
      fqd_pkg::mode_type   op;
      fqd_pkg::handle_type key;
      int                  pick;
      bit                  filling;

      reset           = 1'b1;
      req_chan.valid  = 1'b0;
      req_chan.mode   = fqd_pkg::MODE_ENQ;
      req_chan.handle = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Walk the directed table
      foreach (dir_rows[i]) begin
         row_rsp.status     = dir_rows[i].status;
         row_rsp.out_handle = dir_rows[i].out_handle;
         row_rsp.length     = dir_rows[i].length;
         for (int r = 0; r < dir_rows[i].reps; r++)
            send_op(dir_rows[i].op, dir_rows[i].key + fqd_pkg::handle_type'(r),
                    dir_rows[i].typed, row_rsp);
      end
      drain();

      // Random segments alternate between filling and draining bias
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         filling = (seg % 2 == 0);
         quiet   = (seg == 5 || seg == SEGMENTS - 1);
         foreach (key_pool[p])
            key_pool[p] = $urandom();
         if (seg == 2)
            long_hold_req = 1'b1;
         for (int n = 0; n < SEG_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 2)
               op = MODE_BAD;
            else if (pick < (filling ? 55 : 30))
               op = fqd_pkg::MODE_ENQ;
            else if (pick < (filling ? 78 : 72))
               op = fqd_pkg::MODE_DEQ;
            else
               op = fqd_pkg::MODE_DEL;
            // Draw keys mostly from the pool so deletes find matches
            pick = $urandom_range(0, 99);
            if (pick < 6)
               key = '0;
            else if (pick < 84)
               key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            else
               key = $urandom();
            send_op(op, key, 1'b0, '0);
         end
         if (seg == 4)
            drain();
      end

      // Wait out the last responses plus the longest delete latency
      drain();
      repeat (2 * DEPTH + 10) @(negedge clock);
      if (pending_rsps.size() != 0)
         report_mismatch("responses never returned", '0, 32'(pending_rsps.size()));
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
